// ===== hdl/desfr_pkg.sv =====
// Package with the item types and the DES permutation and S-box tables for the round core.
`timescale 1ns / 1ps
package desfr_pkg;

  localparam int unsigned HALF_W = 32;
  localparam int unsigned KEY_W = 48;
  localparam int unsigned SBOX_N = 8;

  typedef struct packed {
    logic [HALF_W-1:0] left_half;
    logic [HALF_W-1:0] right_half;
    logic [KEY_W-1:0]  round_subkey;
  } desfr_in_t;

  typedef struct packed {
    logic [HALF_W-1:0] new_left;
    logic [HALF_W-1:0] new_right;
  } desfr_out_t;

  localparam logic [5:0] E_TAB [0:KEY_W-1] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [0:HALF_W-1] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  // Each box holds its four rows of sixteen one after another, addressed by {row, column}.
  localparam logic [3:0] SBOX_TAB [0:SBOX_N-1][0:63] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

endpackage

// ===== hdl/desfr_round_fn.sv =====
// Combinational DES round: expansion, subkey mix, S-boxes, P permutation and the half swap.
`timescale 1ns / 1ps
module desfr_round_fn (
  input  desfr_pkg::desfr_in_t  in_i,
  output desfr_pkg::desfr_out_t out_o
);
  import desfr_pkg::*;

  logic [KEY_W-1:0]  expanded;
  logic [KEY_W-1:0]  mixed;
  logic [HALF_W-1:0] sbox_out;
  logic [HALF_W-1:0] f_out;

  // Table entries count bits from 1 at the most significant end.
  always_comb begin
    logic [5:0] pos;
    for (int i = 0; i < KEY_W; i++) begin
      pos = 6'(HALF_W) - E_TAB[i];
      expanded[KEY_W-1-i] = in_i.right_half[pos[4:0]];
    end
  end

  assign mixed = expanded ^ in_i.round_subkey;

  always_comb begin
    logic [5:0] grp;
    for (int i = 0; i < SBOX_N; i++) begin
      grp = mixed[6*(SBOX_N-1-i) +: 6];
      sbox_out[4*(SBOX_N-1-i) +: 4] = SBOX_TAB[i][{grp[5], grp[0], grp[4:1]}];
    end
  end

  always_comb begin
    logic [5:0] pos;
    for (int i = 0; i < HALF_W; i++) begin
      pos = 6'(HALF_W) - P_TAB[i];
      f_out[HALF_W-1-i] = sbox_out[pos[4:0]];
    end
  end

  assign out_o.new_left  = in_i.right_half;
  assign out_o.new_right = in_i.left_half ^ f_out;

endmodule

// ===== hdl/des_feistel_round_core.sv =====
// Top level of the DES Feistel round core: input register, round logic and result register.
// Usage: drive in_i and raise start; an item is taken at every rising edge where start is
// high and busy is low. busy is always low, so one item can be taken in every cycle.
// The item is held in an input register, the round logic works on it during the next
// cycle, and the result is captured in a result register. The result shows on result_o
// for exactly one cycle with strobe_o high: it appears once the result register has taken
// it, and the receiver takes it at the edge that ends that cycle.
// Throughput is one item per cycle; the input register and the result register sit on
// either side of the single round function.
// new_left is the incoming right half; new_right is the left half XOR the round function.
// There is no kept state between items, so items are independent.
// The receiver cannot stall: every result is taken in the cycle it is shown.
// Reset clears both valid flags, so no strobe appears until an item has been taken.
`timescale 1ns / 1ps
module des_feistel_round_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  desfr_pkg::desfr_in_t  in_i,
  output logic                  strobe_o,
  output desfr_pkg::desfr_out_t result_o
);
  import desfr_pkg::*;

  logic       in_vld_q;
  desfr_in_t  in_q;
  desfr_out_t round_d;
  logic       res_vld_q;
  desfr_out_t res_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start && !busy;
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= in_i;
    end
    if (in_vld_q) begin
      res_q <= round_d;
    end
  end

  desfr_round_fn u_round_fn (
    .in_i  (in_q),
    .out_o (round_d)
  );

  assign strobe_o = res_vld_q;
  assign result_o = res_q;

endmodule

// ===== hdl/desfr_checker.sv =====
// Port-level checker for the DES round core, with its bind to the top level.
`timescale 1ns / 1ps
module desfr_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input desfr_pkg::desfr_in_t  in_i,
  input logic                  strobe_o,
  input desfr_pkg::desfr_out_t result_o
);
  import desfr_pkg::*;

  // Every accepted item yields a result once it has passed the input and result registers.
  a_item_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 strobe_o)
    else $error("accepted item produced no result two cycles later");

  // No result appears without a matching item taken before it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start && !busy, 2))
    else $error("result strobe without an accepted item");

  // The new left half is the right half of the item that the result belongs to.
  a_new_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (result_o.new_left == $past(in_i.right_half, 2)))
    else $error("new left half does not match the incoming right half");

endmodule

bind des_feistel_round_core desfr_checker u_desfr_checker (.*);
